/* rtl/quaternion_vector_rotate_macros.svh */
// assertion macros for the quaternion vector rotate block
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property checked on every rising clock edge out of reset
`define QVR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define QVR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define QVR_ASSERT(lbl, clk, rst_n, prop, msg)
`define QVR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/qvr_pkg.sv */
// constants, types and the saturation function of the quaternion vector rotate block
`timescale 1ns / 1ps

package qvr_pkg;

	// field widths
	localparam int QUAT_W    = 16;
	localparam int PORT_W    = 32;
	localparam int VEC_WIDTH = 32;
	localparam int SQ_W      = 2 * QUAT_W;
	localparam int TERM_W    = SQ_W + 2;
	localparam int PROD_W    = TERM_W + VEC_WIDTH;
	localparam int SUM_W     = PROD_W + 2;
	localparam int FRAC      = 28;
	localparam int LATENCY   = 5;

	// rounding offset, one half in q.28 (half of the result lsb)
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC - 1);

	// saturation bounds as seen on the result ports
	localparam logic [PORT_W-1:0] OUT_MAX = PORT_W'({1'b0, {(VEC_WIDTH-1){1'b1}}});
	localparam logic [PORT_W-1:0] OUT_MIN = PORT_W'({1'b1, {(VEC_WIDTH-1){1'b0}}});

	typedef struct packed {
		logic [VEC_WIDTH-1:0] val;
		logic                 clip;
	} row_res_t;

	// shift a rounded row sum down by the fraction bits and clamp to the vector range
	function automatic row_res_t sat_row(input logic signed [SUM_W-1:0] sum);
		logic signed [SUM_W-1:0] q;
		logic [SUM_W-VEC_WIDTH:0] top;
		row_res_t res;
		q   = sum >>> FRAC;
		top = q[SUM_W-1:VEC_WIDTH-1];
		if ((&top) || !(|top)) begin
			res.val  = q[VEC_WIDTH-1:0];
			res.clip = 1'b0;
		end else begin
			res.val  = q[SUM_W-1] ? {1'b1, {(VEC_WIDTH-1){1'b0}}}
			                      : {1'b0, {(VEC_WIDTH-1){1'b1}}};
			res.clip = 1'b1;
		end
		return res;
	endfunction

endpackage

/* rtl/quaternion_vector_rotate.sv */
// quaternion vector rotation pipeline, top level
`timescale 1ns / 1ps

// Rotates a vector by a Q2.14 quaternion through the matrix built from its squares and
// doubled products (no normalization, so a non-unit quaternion scales the result by its
// squared norm). One transfer is taken in every cycle: busy is held low, start alone
// launches an item. Each result leaves the last of the stages below on rot_x, rot_y,
// rot_z and clipped for exactly one cycle with done high; the receiver cannot stall, so
// results must be taken as they appear. The five stages are: quaternion products, matrix
// terms, nine term-by-vector multipliers, row sums with rounding, shift and saturation.
`include "quaternion_vector_rotate_macros.svh"

module quaternion_vector_rotate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_w,
	input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_x,
	input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_y,
	input  logic signed [qvr_pkg::QUAT_W-1:0]   quat_z,
	input  logic signed [qvr_pkg::PORT_W-1:0]   vec_x,
	input  logic signed [qvr_pkg::PORT_W-1:0]   vec_y,
	input  logic signed [qvr_pkg::PORT_W-1:0]   vec_z,
	output logic                                done,
	output logic signed [qvr_pkg::PORT_W-1:0]   rot_x,
	output logic signed [qvr_pkg::PORT_W-1:0]   rot_y,
	output logic signed [qvr_pkg::PORT_W-1:0]   rot_z,
	output logic                                clipped
);

	localparam int SQ_W   = qvr_pkg::SQ_W;
	localparam int TERM_W = qvr_pkg::TERM_W;
	localparam int PROD_W = qvr_pkg::PROD_W;
	localparam int SUM_W  = qvr_pkg::SUM_W;
	localparam int VW     = qvr_pkg::VEC_WIDTH;

	logic in_xfer;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [SQ_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [SQ_W-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [VW-1:0]   v_s1 [3];

	logic signed [TERM_W-1:0] m_s2 [3][3];
	logic signed [VW-1:0]     v_s2 [3];

	logic signed [PROD_W-1:0] p_s3 [3][3];

	logic signed [SUM_W-1:0] sum_s4 [3];

	qvr_pkg::row_res_t res [3];

	logic [qvr_pkg::PORT_W-1:0] rot_s5 [3];
	logic                       clip_s5;

	// the pipeline never holds off a transfer
	assign busy    = 1'b0;
	assign in_xfer = start && !busy;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_xfer;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: squares and cross products of the quaternion
	always_ff @(posedge clk) begin
		ww_s1   <= quat_w * quat_w;
		xx_s1   <= quat_x * quat_x;
		yy_s1   <= quat_y * quat_y;
		zz_s1   <= quat_z * quat_z;
		xy_s1   <= quat_x * quat_y;
		xz_s1   <= quat_x * quat_z;
		yz_s1   <= quat_y * quat_z;
		wx_s1   <= quat_w * quat_x;
		wy_s1   <= quat_w * quat_y;
		wz_s1   <= quat_w * quat_z;
		v_s1[0] <= signed'(VW'(vec_x));
		v_s1[1] <= signed'(VW'(vec_y));
		v_s1[2] <= signed'(VW'(vec_z));
	end

	// stage 2: rotation matrix terms in q.28
	always_ff @(posedge clk) begin
		m_s2[0][0] <= TERM_W'(ww_s1) + TERM_W'(xx_s1) - TERM_W'(yy_s1) - TERM_W'(zz_s1);
		m_s2[0][1] <= (TERM_W'(xy_s1) - TERM_W'(wz_s1)) <<< 1;
		m_s2[0][2] <= (TERM_W'(xz_s1) + TERM_W'(wy_s1)) <<< 1;
		m_s2[1][0] <= (TERM_W'(wz_s1) + TERM_W'(xy_s1)) <<< 1;
		m_s2[1][1] <= TERM_W'(ww_s1) - TERM_W'(xx_s1) + TERM_W'(yy_s1) - TERM_W'(zz_s1);
		m_s2[1][2] <= (TERM_W'(yz_s1) - TERM_W'(wx_s1)) <<< 1;
		m_s2[2][0] <= (TERM_W'(xz_s1) - TERM_W'(wy_s1)) <<< 1;
		m_s2[2][1] <= (TERM_W'(wx_s1) + TERM_W'(yz_s1)) <<< 1;
		m_s2[2][2] <= TERM_W'(ww_s1) - TERM_W'(xx_s1) - TERM_W'(yy_s1) + TERM_W'(zz_s1);
		v_s2       <= v_s1;
	end

	// stage 3: term by vector products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p_s3[i][j] <= m_s2[i][j] * v_s2[j];
			end
		end
	end

	// stage 4: row sums plus the rounding half
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sum_s4[i] <= SUM_W'(p_s3[i][0]) + SUM_W'(p_s3[i][1]) + SUM_W'(p_s3[i][2])
			             + qvr_pkg::ROUND_HALF;
		end
	end

	// stage 5: shift down and saturate each row
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = qvr_pkg::sat_row(sum_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rot_s5[i] <= qvr_pkg::PORT_W'(res[i].val);
		end
		clip_s5 <= res[0].clip || res[1].clip || res[2].clip;
	end

	assign done    = vld_s5;
	assign rot_x   = signed'(rot_s5[0]);
	assign rot_y   = signed'(rot_s5[1]);
	assign rot_z   = signed'(rot_s5[2]);
	assign clipped = clip_s5;

	// every transfer comes out of the pipeline with done high
	`QVR_ASSERT(a_xfer_to_done, clk, arst_n, in_xfer |-> ##5 done, "transfer lost in pipeline")

	// no result without an earlier transfer
	`QVR_ASSERT(a_done_from_xfer, clk, arst_n, done |-> $past(in_xfer, 5),
		"result without transfer")

	// a clipped result carries at least one saturation bound
	`QVR_ASSERT(a_clip_bound, clk, arst_n, (done && clipped) |->
		((rot_x == qvr_pkg::OUT_MAX) || (rot_x == qvr_pkg::OUT_MIN) ||
		(rot_y == qvr_pkg::OUT_MAX) || (rot_y == qvr_pkg::OUT_MIN) ||
		(rot_z == qvr_pkg::OUT_MAX) || (rot_z == qvr_pkg::OUT_MIN)),
		"clipped without bound value")

endmodule

/* tb/sv/quaternion_vector_rotate_tb.sv */
// self-checking testbench for the quaternion vector rotate block
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;

	localparam int QUAT_W       = qvr_pkg::QUAT_W;
	localparam int PORT_W       = qvr_pkg::PORT_W;
	localparam int VEC_WIDTH    = qvr_pkg::VEC_WIDTH;
	localparam int FRAC         = qvr_pkg::FRAC;
	localparam int LATENCY      = qvr_pkg::LATENCY;
	localparam int ACC_W       = 80;
	localparam int RANDOM_ITEMS = 1800;

	typedef logic signed [ACC_W-1:0] acc_t;

	// one rotation request with the idle cycles that precede its transfer
	typedef struct {
		logic signed [QUAT_W-1:0] w, x, y, z;
		logic signed [PORT_W-1:0] vx, vy, vz;
		int                       gap;
	} rotation_req_t;

	typedef struct {
		logic [PORT_W-1:0] rx, ry, rz;
		logic              clip;
	} rotated_vec_t;

	localparam acc_t ROUND_OFS = acc_t'(1) <<< (FRAC - 1);
	localparam acc_t VEC_HI    = (acc_t'(1) <<< (VEC_WIDTH - 1)) - acc_t'(1);
	localparam acc_t VEC_LO    = -(acc_t'(1) <<< (VEC_WIDTH - 1));

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic busy;
	logic signed [QUAT_W-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic signed [PORT_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic                     done;
	logic signed [PORT_W-1:0] rot_x, rot_y, rot_z;
	logic                     clipped;

	rotation_req_t pending_rotations[$];
	rotated_vec_t  expected_rotations[$];
	rotation_req_t staged_req, driven_req;
	bit            staged_valid = 1'b0;
	int            hold_cycles = 0;
	bit            no_idle_run = 1'b0;
	int            mismatch_count = 0;

	quaternion_vector_rotate DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.quat_w  (quat_w),
		.quat_x  (quat_x),
		.quat_y  (quat_y),
		.quat_z  (quat_z),
		.vec_x   (vec_x),
		.vec_y   (vec_y),
		.vec_z   (vec_z),
		.done    (done),
		.rot_x   (rot_x),
		.rot_y   (rot_y),
		.rot_z   (rot_z),
		.clipped (clipped)
	);

	// rotation matrix from the raw quaternion, exact row sums, round half up, clamp
	function automatic rotated_vec_t rotate_vector(input rotation_req_t r);
		acc_t w, x, y, z, vx, vy, vz;
		acc_t ww, xx, yy, zz, xy2, xz2, yz2, wx2, wy2, wz2;
		acc_t m[9];
		acc_t sum, q;
		logic [PORT_W-1:0] comp[3];
		rotated_vec_t res;
		w  = acc_t'(r.w);
		x  = acc_t'(r.x);
		y  = acc_t'(r.y);
		z  = acc_t'(r.z);
		vx = acc_t'(signed'(r.vx[VEC_WIDTH-1:0]));
		vy = acc_t'(signed'(r.vy[VEC_WIDTH-1:0]));
		vz = acc_t'(signed'(r.vz[VEC_WIDTH-1:0]));
		ww = w * w;
		xx = x * x;
		yy = y * y;
		zz = z * z;
		xy2 = 2 * x * y;
		xz2 = 2 * x * z;
		yz2 = 2 * y * z;
		wx2 = 2 * w * x;
		wy2 = 2 * w * y;
		wz2 = 2 * w * z;
		m[0] = ww + xx - yy - zz;  m[1] = xy2 - wz2;        m[2] = xz2 + wy2;
		m[3] = wz2 + xy2;          m[4] = ww - xx + yy - zz; m[5] = yz2 - wx2;
		m[6] = xz2 - wy2;          m[7] = wx2 + yz2;        m[8] = ww - xx - yy + zz;
		res.clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sum = m[3*i] * vx + m[3*i+1] * vy + m[3*i+2] * vz;
			q   = (sum + ROUND_OFS) >>> FRAC;
			if (q > VEC_HI) begin
				q        = VEC_HI;
				res.clip = 1'b1;
			end else if (q < VEC_LO) begin
				q        = VEC_LO;
				res.clip = 1'b1;
			end
			comp[i] = PORT_W'(q[VEC_WIDTH-1:0]);
		end
		res.rx = comp[0];
		res.ry = comp[1];
		res.rz = comp[2];
		return res;
	endfunction

	task automatic add_rotation(input int w, input int x, input int y, input int z,
			input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
		rotation_req_t r;
		r.w   = QUAT_W'(w);
		r.x   = QUAT_W'(x);
		r.y   = QUAT_W'(y);
		r.z   = QUAT_W'(z);
		r.vx  = PORT_W'(vx);
		r.vy  = PORT_W'(vy);
		r.vz  = PORT_W'(vz);
		r.gap = no_idle_run ? 0 : $urandom_range(0, 4);
		pending_rotations.push_back(r);
	endtask

	// quaternion component: full range, unit, small, an extreme or up to about 1/sqrt2 in size
	function automatic int rand_quat_comp();
		case ($urandom_range(0, 5))
			0, 1: return int'($signed(16'($urandom)));
			2:    return $urandom_range(0, 1) ? 16384 : -16384;
			3:    return int'($urandom_range(0, 4000)) - 2000;
			4:    return $urandom_range(0, 1) ? 32767 : -32768;
			default: return int'($urandom_range(0, 23170)) - 11585;
		endcase
	endfunction

	// vector component: full range, small, an extreme or a power of two
	function automatic logic [31:0] rand_vec_comp();
		case ($urandom_range(0, 4))
			0, 1: return $urandom;
			2:    return 32'(int'($urandom_range(0, 2000000)) - 1000000);
			3:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'(1) << $urandom_range(0, 31);
		endcase
	endfunction

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// driver: one transfer per accepted item, noise on the fields while idle
	always @(posedge clk) begin
		bit next_start;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			next_start = start && busy;
			if (start && !busy)
				expected_rotations.push_back(rotate_vector(driven_req));
			if (!next_start && !staged_valid && pending_rotations.size() != 0) begin
				staged_req   = pending_rotations.pop_front();
				staged_valid = 1'b1;
				hold_cycles  = staged_req.gap;
			end
			if (!next_start && staged_valid) begin
				if (hold_cycles == 0) begin
					driven_req   = staged_req;
					staged_valid = 1'b0;
					next_start   = 1'b1;
				end else begin
					hold_cycles--;
				end
			end
			start <= next_start;
			if (next_start) begin
				quat_w <= driven_req.w;
				quat_x <= driven_req.x;
				quat_y <= driven_req.y;
				quat_z <= driven_req.z;
				vec_x  <= driven_req.vx;
				vec_y  <= driven_req.vy;
				vec_z  <= driven_req.vz;
			end else begin
				quat_w <= QUAT_W'($urandom);
				quat_x <= QUAT_W'($urandom);
				quat_y <= QUAT_W'($urandom);
				quat_z <= QUAT_W'($urandom);
				vec_x  <= $urandom;
				vec_y  <= $urandom;
				vec_z  <= $urandom;
			end
		end
	end

	// monitor: each done strobe against the oldest expected rotation
	always @(posedge clk) begin
		rotated_vec_t exp_rot;
		if (arst_n && done) begin
			if (expected_rotations.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %0d %0d %0d clipped %0b",
						rot_x, rot_y, rot_z, clipped);
			end else begin
				exp_rot = expected_rotations.pop_front();
				if (rot_x !== exp_rot.rx || rot_y !== exp_rot.ry ||
						rot_z !== exp_rot.rz || clipped !== exp_rot.clip) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %0d %0d %0d clipped %0b, got %0d %0d %0d clipped %0b",
							$signed(exp_rot.rx), $signed(exp_rot.ry), $signed(exp_rot.rz),
							exp_rot.clip, rot_x, rot_y, rot_z, clipped);
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int waited;
		// identity on extreme and unit vectors
		add_rotation(16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
		add_rotation(16384, 0, 0, 0, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000);
		// half turns about each axis and the identity with w negated
		add_rotation(0, 16384, 0, 0, 32'd1000, 32'd2000, 32'd3000);
		add_rotation(0, 0, 16384, 0, 32'd1000, 32'd2000, 32'd3000);
		add_rotation(0, 0, 0, 16384, 32'd1000, 32'd2000, 32'd3000);
		add_rotation(-16384, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5);
		// quarter turns, quaternion only close to unit length
		add_rotation(11585, 0, 0, 11585, 32'd100000, 32'd0, 32'd0);
		add_rotation(11585, 11585, 0, 0, 32'd0, 32'd100000, 32'd7);
		add_rotation(11585, 0, -11585, 0, 32'd0, 32'd0, 32'd100000);
		// rounding ties: half-length scalar part gives a quarter-scale matrix
		add_rotation(8192, 0, 0, 0, 32'd2, 32'hFFFF_FFFE, 32'hFFFF_FFFA);
		add_rotation(8192, 0, 0, 0, 32'd6, 32'd1, 32'hFFFF_FFFF);
		// zero quaternion
		add_rotation(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
		// non-unit quaternions that scale the vector
		add_rotation(32767, 0, 0, 0, 32'd1000, 32'hFFFF_FC18, 32'd1);
		add_rotation(20000, 5000, -3000, 100, 32'd123456, 32'd654321, 32'hFFF0_0000);
		// overflow in every direction
		add_rotation(32767, 32767, 32767, 32767, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_rotation(-32768, -32768, -32768, -32768, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000);
		add_rotation(32767, 0, 0, 0, 32'h8000_0000, 32'd0, 32'd0);
		add_rotation(0, -32768, 0, 0, 32'd0, 32'h7FFF_FFFF, 32'd0);
		add_rotation(0, 0, -32768, 0, 32'd0, 32'd0, 32'h8000_0000);
		add_rotation(0, 0, 0, -32768, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		add_rotation(-32768, 32767, -32768, 32767, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		// random part in runs, some with no idle cycles between transfers
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 60 == 0)
				no_idle_run = ($urandom_range(0, 2) == 0);
			add_rotation(rand_quat_comp(), rand_quat_comp(), rand_quat_comp(), rand_quat_comp(),
				rand_vec_comp(), rand_vec_comp(), rand_vec_comp());
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// all items transferred
		do @(negedge clk);
		while (pending_rotations.size() != 0 || staged_valid || start);
		// drain the pipeline
		waited = 0;
		while (expected_rotations.size() != 0 && waited < 20 * LATENCY) begin
			@(negedge clk);
			waited++;
		end
		repeat (LATENCY + 3) @(negedge clk);
		if (expected_rotations.size() != 0)
			$display("%0d expected results never arrived", expected_rotations.size());
		if (mismatch_count == 0 && expected_rotations.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
